/* design/gbc_pkg.sv */
// ----------------------------------------------------------------------------
// gbc_pkg: shared definitions for the glyph blitter
// Font geometry, store sizes, command and register codes and the packed
// layout of one glyph metrics entry.
// ----------------------------------------------------------------------------
`default_nettype none

package gbc_pkg;

    localparam int GLYPH_COUNT     = 256;
    localparam int GLYPH_SIDE      = 8;
    localparam int PALETTE_ENTRIES = 16;

    localparam int SIDE_W        = 3;
    localparam int PIX_PER_GLYPH = 64;
    localparam int GLYPH_AW      = $clog2(GLYPH_COUNT);
    localparam int PIX_AW        = GLYPH_AW + $clog2(PIX_PER_GLYPH);
    localparam int PIX_DEPTH     = GLYPH_COUNT * PIX_PER_GLYPH;
    localparam int PAL_AW        = $clog2(PALETTE_ENTRIES);

    localparam logic [2:0] CMD_LOAD_METRICS = 3'd0;
    localparam logic [2:0] CMD_LOAD_PIXEL   = 3'd1;
    localparam logic [2:0] CMD_LOAD_PALETTE = 3'd2;
    localparam logic [2:0] CMD_SET_PEN      = 3'd3;
    localparam logic [2:0] CMD_DRAW         = 3'd4;

    localparam logic [2:0] CFG_ROW_STRIDE  = 3'd0;
    localparam logic [2:0] CFG_CLIP_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_CLIP_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_ORIGIN_X    = 3'd3;
    localparam logic [2:0] CFG_ORIGIN_Y    = 3'd4;
    localparam logic [2:0] CFG_MAX_CODE    = 3'd5;

    typedef struct packed {
        logic signed [7:0] offset_x;
        logic signed [7:0] offset_y;
        logic [3:0]        width;
        logic [3:0]        height;
    } t_metrics;

endpackage

`default_nettype wire

/* design/gbc_if.sv */
// ----------------------------------------------------------------------------
// gbc_if: channel interfaces of the glyph blitter
// Command input, pixel result output and register write channels, each a
// valid/ready pair with its payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbc_in_if
    import gbc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic [7:0]         glyph_code;
    logic [5:0]         pixel_index;
    logic [7:0]         pixel_value;
    logic [3:0]         palette_slot;
    logic signed [7:0]  offset_x;
    logic signed [7:0]  offset_y;
    logic [3:0]         glyph_width;
    logic [3:0]         glyph_height;
    logic signed [15:0] new_pen_x;
    logic signed [15:0] new_pen_y;

    modport source (
        output valid, command, glyph_code, pixel_index, pixel_value, palette_slot,
        output offset_x, offset_y, glyph_width, glyph_height, new_pen_x, new_pen_y,
        input  ready
    );
    modport sink (
        input  valid, command, glyph_code, pixel_index, pixel_value, palette_slot,
        input  offset_x, offset_y, glyph_width, glyph_height, new_pen_x, new_pen_y,
        output ready
    );
endinterface

interface gbc_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_address;
    logic [7:0]  pixel_color;
    logic        status;
    logic        last_of_glyph;

    modport source (
        output valid, pixel_address, pixel_color, status, last_of_glyph,
        input  ready
    );
    modport sink (
        input  valid, pixel_address, pixel_color, status, last_of_glyph,
        output ready
    );
endinterface

interface gbc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [11:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/gbc_ram.sv */
// ----------------------------------------------------------------------------
// gbc_ram: generic single-clock RAM
// One write port and one read port; the read data is registered and holds
// while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module gbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* design/glyph_blit_with_clip.sv */
// ----------------------------------------------------------------------------
// glyph_blit_with_clip: bitmap font glyph blitter with clipping
// Loads glyph metrics, glyph pixels, palette and pen, and renders glyphs as
// a stream of frame buffer pixel writes clipped to a window.
// ----------------------------------------------------------------------------
// Commands arrive as beats on i_in; pixel writes leave as beats on o_out;
// registers are written through i_cfg, which is always ready and must only
// be used while the block is idle.
// Load and set-pen commands leave the sequencer idle. A draw occupies the
// sequencer with a metrics read, then one glyph pixel per advancing cycle
// from the pixel memory, then one end-of-glyph beat; an empty glyph skips
// the pixels and a bad code gives a single error beat. i_in is ready again
// once the sequencer is idle and its last token has left stage 1.
// Visible pixels pass through a pixel memory read, a palette read and a row
// multiply; the last visible pixel is held back until the end of the glyph
// so that it can be flagged as the final one.
// When o_out stalls, the pixel pipeline freezes; one finished result waits
// in the output register and one in the hold-back stage. Reset clears the
// pen, returns the registers to their defaults and clears the pipeline valid
// flags; the memories need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_blit_with_clip
    import gbc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    gbc_in_if.sink      i_in,
    gbc_out_if.source   o_out,
    gbc_cfg_if.sink     i_cfg
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_META  = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_ERR   = 3'd4;

    localparam logic [1:0] TK_PIX   = 2'd0;
    localparam logic [1:0] TK_FLUSH = 2'd1;
    localparam logic [1:0] TK_ERR   = 2'd2;

    function automatic logic [3:0] sat_side(input logic [3:0] v);
        sat_side = (v > 4'(GLYPH_SIDE)) ? 4'(GLYPH_SIDE) : v;
    endfunction

    // Registers.
    logic [11:0]        r_row_stride;
    logic [11:0]        r_clip_width;
    logic [11:0]        r_clip_height;
    logic signed [11:0] r_origin_x;
    logic signed [11:0] r_origin_y;
    logic [7:0]         r_max_code;

    // Sequencer.
    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic signed [15:0]    r_pen_x;
    logic signed [15:0]    r_pen_y;
    logic [GLYPH_AW-1:0]   r_code;
    logic signed [17:0]    r_dx;
    logic signed [17:0]    r_dy;
    logic [3:0]            r_w;
    logic [3:0]            r_h;
    logic [SIDE_W-1:0]     r_x;
    logic [SIDE_W-1:0]     r_y;

    // Pipeline.
    logic                  r_s1_v;
    logic [1:0]            r_s1_kind;
    logic                  r_s1_vis;
    logic [11:0]           r_s1_row;
    logic [11:0]           r_s1_col;
    logic                  r_s2_v;
    logic [1:0]            r_s2_kind;
    logic                  r_s2_keep;
    logic [23:0]           r_s2_prod;
    logic [11:0]           r_s2_col;
    logic                  r_pend_v;
    logic [23:0]           r_pend_addr;
    logic [7:0]            r_pend_color;
    logic                  r_out_v;
    logic [23:0]           r_out_addr;
    logic [7:0]            r_out_color;
    logic                  r_out_status;
    logic                  r_out_last;

    logic                  in_fire;
    logic                  code_ok;
    logic                  draw_bad;
    logic                  slot_ok;
    t_metrics              met_wdata;
    logic [23:0]           met_rdata;
    t_metrics              met;
    logic signed [17:0]    dx_calc;
    logic signed [17:0]    dy_calc;
    logic                  last_x;
    logic                  last_y;
    logic                  s0_issue;
    logic [1:0]            s0_kind;
    logic signed [17:0]    row_s0;
    logic signed [17:0]    col_s0;
    logic                  vis_s0;
    logic [7:0]            pix_rdata;
    logic                  color_ok;
    logic [7:0]            color_m1;
    logic [7:0]            pal_rdata;
    logic [23:0]           s2_addr;
    logic                  s2_out;
    logic                  out_free;
    logic                  adv;

    assign in_fire   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE) && !r_s1_v;
    assign i_cfg.ready = 1'b1;

    assign code_ok  = {1'b0, i_in.glyph_code} < 9'(GLYPH_COUNT);
    assign draw_bad = (i_in.glyph_code > r_max_code) || !code_ok;
    assign slot_ok  = {1'b0, i_in.palette_slot} < 5'(PALETTE_ENTRIES);

    assign met_wdata.offset_x = i_in.offset_x;
    assign met_wdata.offset_y = i_in.offset_y;
    assign met_wdata.width    = sat_side(i_in.glyph_width);
    assign met_wdata.height   = sat_side(i_in.glyph_height);

    gbc_ram #(
        .WIDTH ($bits(t_metrics)),
        .DEPTH (GLYPH_COUNT)
    ) u_metrics_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && (i_in.command == CMD_LOAD_METRICS) && code_ok),
        .i_waddr (i_in.glyph_code[GLYPH_AW-1:0]),
        .i_wdata (met_wdata),
        .i_re    (in_fire && (i_in.command == CMD_DRAW)),
        .i_raddr (i_in.glyph_code[GLYPH_AW-1:0]),
        .o_rdata (met_rdata)
    );

    assign met     = t_metrics'(met_rdata);
    assign dx_calc = 18'(r_origin_x) + 18'(r_pen_x) + 18'(met.offset_x);
    assign dy_calc = 18'(r_origin_y) + 18'(r_pen_y) + 18'(met.offset_y);

    assign last_x = ({1'b0, r_x} + 4'd1) == r_w;
    assign last_y = ({1'b0, r_y} + 4'd1) == r_h;

    // Stage 0: sequencer issues one token per advancing cycle in the walk, flush and error states.
    always_comb begin
        s0_issue = 1'b0;
        s0_kind  = TK_PIX;
        case (r_state)
            ST_WALK: begin
                s0_issue = adv;
                s0_kind  = TK_PIX;
            end
            ST_FLUSH: begin
                s0_issue = adv;
                s0_kind  = TK_FLUSH;
            end
            ST_ERR: begin
                s0_issue = adv;
                s0_kind  = TK_ERR;
            end
            default: begin
                s0_issue = 1'b0;
                s0_kind  = TK_PIX;
            end
        endcase
    end

    assign row_s0 = r_dy + 18'(r_y);
    assign col_s0 = r_dx + 18'(r_x);
    assign vis_s0 = !row_s0[17] && (row_s0 < {6'd0, r_clip_height})
                 && !col_s0[17] && (col_s0 < {6'd0, r_clip_width});

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && (i_in.command == CMD_DRAW)) begin
                    n_state = draw_bad ? ST_ERR : ST_META;
                end
            end
            ST_META: begin
                n_state = ((met.width == 4'd0) || (met.height == 4'd0)) ? ST_FLUSH : ST_WALK;
            end
            ST_WALK: begin
                if (adv && last_x && last_y) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH, ST_ERR: begin
                if (adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pen_x      <= '0;
            r_pen_y      <= '0;
            r_row_stride  <= 12'd320;
            r_clip_width  <= 12'd320;
            r_clip_height <= 12'd200;
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_max_code    <= 8'd255;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_ROW_STRIDE:  r_row_stride  <= i_cfg.data;
                    CFG_CLIP_WIDTH:  r_clip_width  <= i_cfg.data;
                    CFG_CLIP_HEIGHT: r_clip_height <= i_cfg.data;
                    CFG_ORIGIN_X:    r_origin_x    <= i_cfg.data;
                    CFG_ORIGIN_Y:    r_origin_y    <= i_cfg.data;
                    CFG_MAX_CODE:    r_max_code    <= i_cfg.data[7:0];
                    default: ;
                endcase
            end
            if (in_fire && (i_in.command == CMD_SET_PEN)) begin
                r_pen_x <= i_in.new_pen_x;
                r_pen_y <= i_in.new_pen_y;
            end
            if (r_state == ST_META) begin
                r_pen_x <= r_pen_x + 16'(met.offset_x) + 16'(met.width);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_code <= i_in.glyph_code[GLYPH_AW-1:0];
        end
        if (r_state == ST_META) begin
            r_dx <= dx_calc;
            r_dy <= dy_calc;
            r_w  <= met.width;
            r_h  <= met.height;
            r_x  <= '0;
            r_y  <= '0;
        end else if ((r_state == ST_WALK) && adv) begin
            if (last_x) begin
                r_x <= '0;
                r_y <= r_y + 1'b1;
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
    end

    gbc_ram #(
        .WIDTH (8),
        .DEPTH (PIX_DEPTH)
    ) u_pixel_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && (i_in.command == CMD_LOAD_PIXEL) && code_ok),
        .i_waddr ({i_in.glyph_code[GLYPH_AW-1:0], i_in.pixel_index}),
        .i_wdata (i_in.pixel_value),
        .i_re    (adv),
        .i_raddr ({r_code, r_y, r_x}),
        .o_rdata (pix_rdata)
    );

    // Stage 1: colour index check, palette lookup and row multiply.
    assign color_ok = (pix_rdata != 8'd0) && (pix_rdata < 8'(PALETTE_ENTRIES));
    assign color_m1 = pix_rdata - 8'd1;

    gbc_ram #(
        .WIDTH (8),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && (i_in.command == CMD_LOAD_PALETTE) && slot_ok),
        .i_waddr (i_in.palette_slot[PAL_AW-1:0]),
        .i_wdata (i_in.pixel_value),
        .i_re    (adv),
        .i_raddr (color_m1[PAL_AW-1:0]),
        .o_rdata (pal_rdata)
    );

    // Stage 2: the hold-back stage decides which result goes out.
    assign s2_addr  = r_s2_prod + {12'd0, r_s2_col};
    assign s2_out   = r_s2_v && (((r_s2_kind == TK_PIX) && r_s2_keep && r_pend_v)
                   || ((r_s2_kind == TK_FLUSH) && r_pend_v)
                   || (r_s2_kind == TK_ERR));
    assign out_free = !r_out_v || o_out.ready;
    assign adv      = !(s2_out && !out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (adv) begin
                r_s1_v <= s0_issue;
                r_s2_v <= r_s1_v;
                if (r_s2_v && (r_s2_kind == TK_PIX) && r_s2_keep) begin
                    r_pend_v <= 1'b1;
                end else if (r_s2_v && (r_s2_kind == TK_FLUSH)) begin
                    r_pend_v <= 1'b0;
                end
            end
            if (adv && s2_out) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_kind <= s0_kind;
            r_s1_vis  <= vis_s0;
            r_s1_row  <= row_s0[11:0];
            r_s1_col  <= col_s0[11:0];
            r_s2_kind <= r_s1_kind;
            r_s2_keep <= r_s1_vis && color_ok;
            r_s2_prod <= {12'd0, r_s1_row} * {12'd0, r_row_stride};
            r_s2_col  <= r_s1_col;
            if (r_s2_v && (r_s2_kind == TK_PIX) && r_s2_keep) begin
                r_pend_addr  <= s2_addr;
                r_pend_color <= pal_rdata;
            end
        end
        if (adv && s2_out) begin
            case (r_s2_kind)
                TK_PIX: begin
                    r_out_addr   <= r_pend_addr;
                    r_out_color  <= r_pend_color;
                    r_out_status <= 1'b0;
                    r_out_last   <= 1'b0;
                end
                TK_FLUSH: begin
                    r_out_addr   <= r_pend_addr;
                    r_out_color  <= r_pend_color;
                    r_out_status <= 1'b0;
                    r_out_last   <= 1'b1;
                end
                default: begin
                    r_out_addr   <= '0;
                    r_out_color  <= '0;
                    r_out_status <= 1'b1;
                    r_out_last   <= 1'b1;
                end
            endcase
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.pixel_address = r_out_addr;
    assign o_out.pixel_color   = r_out_color;
    assign o_out.status        = r_out_status;
    assign o_out.last_of_glyph = r_out_last;

endmodule

`default_nettype wire

/* design/gbc_checker.sv */
// ----------------------------------------------------------------------------
// gbc_checker: port-level checks for the glyph blitter
// Watches the command and result channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module gbc_checker
    import gbc_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire [2:0]  i_in_command,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [23:0] i_out_address,
    input wire [7:0]  i_out_color,
    input wire        i_out_status,
    input wire        i_out_last
);

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_address)
            && $stable(i_out_color) && $stable(i_out_status) && $stable(i_out_last))
        else $error("result beat changed while stalled");

    // An error result is an empty, final beat.
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status |-> i_out_last && (i_out_address == 24'd0)
            && (i_out_color == 8'd0))
        else $error("malformed error beat");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A draw keeps the command channel busy for at least the metrics read.
    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_command == CMD_DRAW) |=> !i_in_ready)
        else $error("command accepted during metrics read");

endmodule

bind glyph_blit_with_clip gbc_checker u_gbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_command  (i_in.command),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_address (o_out.pixel_address),
    .i_out_color   (o_out.pixel_color),
    .i_out_status  (o_out.status),
    .i_out_last    (o_out.last_of_glyph)
);

`default_nettype wire
